/* rtl/jsh_pkg.sv */
// shared types, constants and decode functions of the segment header parser
package jsh_pkg;

  localparam logic [1:0] KIND_FILE_HDR = 2'd0;
  localparam logic [1:0] KIND_SEG_HDR  = 2'd1;
  localparam logic [1:0] KIND_BAD_ID   = 2'd2;
  localparam logic [1:0] KIND_BAD_TYPE = 2'd3;

  localparam logic [5:0] TYPE_PAGE_INFO     = 6'd48;
  localparam logic [5:0] TYPE_END_OF_PAGE   = 6'd49;
  localparam logic [5:0] TYPE_END_OF_STRIPE = 6'd50;
  localparam logic [5:0] TYPE_END_OF_FILE   = 6'd51;

  localparam logic [31:0] REF_NARROW_MAX = 32'd256;
  localparam logic [31:0] REF_MID_MAX    = 32'd65536;
  localparam logic [2:0]  REF_LONG_FORM  = 3'd7;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  kind;
    logic        seq_org;
    logic [31:0] page_count;
    logic [31:0] seg_number;
    logic [5:0]  seg_type;
    logic [28:0] ref_count;
    logic [31:0] page_assoc;
    logic [31:0] data_length;
  } rec_t;

  function automatic logic [7:0] id_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0: v = 8'h97;
      3'd1: v = 8'h4A;
      3'd2: v = 8'h42;
      3'd3: v = 8'h32;
      3'd4: v = 8'h0D;
      3'd5: v = 8'h0A;
      3'd6: v = 8'h1A;
      default: v = 8'h0A;
    endcase
    return v;
  endfunction

  function automatic logic type_known(input logic [5:0] t);
    logic k;
    case (t) inside
      6'd0, 6'd4, 6'd6, 6'd7, 6'd16, 6'd20, 6'd22, 6'd23,
      6'd36, 6'd38, 6'd39, 6'd40, 6'd42, 6'd43,
      [6'd48:6'd53], 6'd62: k = 1'b1;
      default: k = 1'b0;
    endcase
    return k;
  endfunction

endpackage

/* rtl/jsh_front.sv */
// byte parser: walks file and segment header fields, pushes one record per header or bad ID string
module jsh_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          beat_i,
  input  logic [7:0]    data_byte_i,
  input  logic          restart_i,
  output logic          push_o,
  output jsh_pkg::rec_t rec_o
);
  import jsh_pkg::*;

  localparam logic [3:0] PH_ID        = 4'd0;
  localparam logic [3:0] PH_FHFLAGS   = 4'd1;
  localparam logic [3:0] PH_PAGES     = 4'd2;
  localparam logic [3:0] PH_SEGNUM    = 4'd3;
  localparam logic [3:0] PH_SEGFLAGS  = 4'd4;
  localparam logic [3:0] PH_REFBYTE   = 4'd5;
  localparam logic [3:0] PH_REFLONG   = 4'd6;
  localparam logic [3:0] PH_RETAIN    = 4'd7;
  localparam logic [3:0] PH_REFNUMS   = 4'd8;
  localparam logic [3:0] PH_PAGEASSOC = 4'd9;
  localparam logic [3:0] PH_DATALEN   = 4'd10;
  localparam logic [3:0] PH_SKIPDATA  = 4'd11;
  localparam logic [3:0] PH_DONE      = 4'd12;
  localparam logic [3:0] PH_ERROR     = 4'd13;

  logic [3:0]  phase_q, phase_d, ph;
  logic [31:0] cnt_q, cnt_d, cnt;
  logic [31:0] fs_q, fs_d, fs;
  logic [31:0] segn_q, segn_d, segn;
  logic [7:0]  flg_q, flg_d, flg;
  logic [28:0] refc_q, refc_d, refc;
  logic [31:0] pa_q, pa_d, pa;
  logic        seq_q, seq_d, seq;
  logic [31:0] pages_q, pages_d, pages;

  logic [31:0] fs_shift, dec, ref_bytes;
  logic [1:0]  ref_w;
  logic        emit, emit_seg;
  logic [1:0]  emit_kind;
  logic [31:0] emit_dlen;

  always_comb begin
    // restart behaves as a reset in front of this byte
    ph    = restart_i ? PH_ID : phase_q;
    cnt   = restart_i ? '0 : cnt_q;
    fs    = restart_i ? '0 : fs_q;
    segn  = restart_i ? '0 : segn_q;
    flg   = restart_i ? '0 : flg_q;
    refc  = restart_i ? '0 : refc_q;
    pa    = restart_i ? '0 : pa_q;
    seq   = restart_i ? 1'b0 : seq_q;
    pages = restart_i ? '0 : pages_q;

    phase_d = ph;   cnt_d = cnt;  fs_d = fs;   segn_d = segn; flg_d = flg;
    refc_d  = refc; pa_d  = pa;   seq_d = seq; pages_d = pages;
    emit = 1'b0; emit_seg = 1'b0; emit_kind = KIND_FILE_HDR; emit_dlen = '0;

    fs_shift  = {fs[23:0], data_byte_i};
    dec       = cnt - 32'd1;
    ref_w     = (segn <= REF_NARROW_MAX) ? 2'd0 : ((segn <= REF_MID_MAX) ? 2'd1 : 2'd2);
    ref_bytes = '0;

    unique case (ph)
      PH_ID: begin
        if (data_byte_i != id_byte(cnt[2:0])) begin
          emit = 1'b1; emit_kind = KIND_BAD_ID; phase_d = PH_ERROR;
        end else if (cnt[2:0] == 3'd7) begin
          cnt_d = '0; phase_d = PH_FHFLAGS;
        end else begin
          cnt_d = cnt + 32'd1;
        end
      end
      PH_FHFLAGS: begin
        seq_d = data_byte_i[0];
        if (data_byte_i[1]) begin
          pages_d = '0; emit = 1'b1; emit_kind = KIND_FILE_HDR;
          phase_d = PH_SEGNUM; cnt_d = 32'd4; fs_d = '0;
        end else begin
          phase_d = PH_PAGES; cnt_d = 32'd4; fs_d = '0;
        end
      end
      PH_PAGES: begin
        fs_d = fs_shift; cnt_d = dec;
        if (dec == '0) begin
          pages_d = fs_shift; emit = 1'b1; emit_kind = KIND_FILE_HDR;
          phase_d = PH_SEGNUM; cnt_d = 32'd4; fs_d = '0;
        end
      end
      PH_SEGNUM: begin
        fs_d = fs_shift; cnt_d = dec;
        if (dec == '0) begin
          segn_d = fs_shift; phase_d = PH_SEGFLAGS;
        end
      end
      PH_SEGFLAGS: begin
        flg_d = data_byte_i; refc_d = '0; pa_d = '0;
        if (!type_known(data_byte_i[5:0])) begin
          emit = 1'b1; emit_seg = 1'b1; emit_kind = KIND_BAD_TYPE; phase_d = PH_ERROR;
        end else if (seq && data_byte_i[5:0] == TYPE_END_OF_FILE) begin
          emit = 1'b1; emit_seg = 1'b1; emit_kind = KIND_SEG_HDR; phase_d = PH_DONE;
        end else begin
          phase_d = PH_REFBYTE;
        end
      end
      PH_REFBYTE: begin
        if (data_byte_i[7:5] == REF_LONG_FORM) begin
          fs_d = {27'd0, data_byte_i[4:0]}; cnt_d = 32'd3; phase_d = PH_REFLONG;
        end else begin
          refc_d    = {26'd0, data_byte_i[7:5]};
          ref_bytes = {3'd0, refc_d} << ref_w;
          if (ref_bytes == '0) begin
            phase_d = PH_PAGEASSOC; cnt_d = flg[6] ? 32'd4 : 32'd1; fs_d = '0;
          end else begin
            phase_d = PH_REFNUMS; cnt_d = ref_bytes;
          end
        end
      end
      PH_REFLONG: begin
        fs_d = fs_shift; cnt_d = dec;
        if (dec == '0) begin
          refc_d  = fs_shift[28:0];
          cnt_d   = ({3'd0, fs_shift[28:0]} + 32'd8) >> 3;
          phase_d = PH_RETAIN;
        end
      end
      PH_RETAIN: begin
        cnt_d = dec;
        if (dec == '0) begin
          ref_bytes = {3'd0, refc} << ref_w;
          if (ref_bytes == '0) begin
            phase_d = PH_PAGEASSOC; cnt_d = flg[6] ? 32'd4 : 32'd1; fs_d = '0;
          end else begin
            phase_d = PH_REFNUMS; cnt_d = ref_bytes;
          end
        end
      end
      PH_REFNUMS: begin
        cnt_d = dec;
        if (dec == '0) begin
          phase_d = PH_PAGEASSOC; cnt_d = flg[6] ? 32'd4 : 32'd1; fs_d = '0;
        end
      end
      PH_PAGEASSOC: begin
        fs_d = fs_shift; cnt_d = dec;
        if (dec == '0) begin
          pa_d = fs_shift; phase_d = PH_DATALEN; cnt_d = 32'd4; fs_d = '0;
        end
      end
      PH_DATALEN: begin
        fs_d = fs_shift; cnt_d = dec;
        if (dec == '0) begin
          emit = 1'b1; emit_seg = 1'b1; emit_kind = KIND_SEG_HDR; emit_dlen = fs_shift;
          if (flg[5:0] == TYPE_END_OF_FILE) begin
            phase_d = PH_DONE;
          end else if (seq && fs_shift != '0) begin
            cnt_d = fs_shift; phase_d = PH_SKIPDATA;
          end else begin
            phase_d = PH_SEGNUM; cnt_d = 32'd4; fs_d = '0;
          end
        end
      end
      PH_SKIPDATA: begin
        cnt_d = dec;
        if (dec == '0) begin
          phase_d = PH_SEGNUM; cnt_d = 32'd4; fs_d = '0;
        end
      end
      default: ;
    endcase
  end

  assign push_o = beat_i && emit;

  always_comb begin
    rec_o.kind        = emit_kind;
    rec_o.seq_org     = seq_d;
    rec_o.page_count  = pages_d;
    rec_o.seg_number  = emit_seg ? segn_d : '0;
    rec_o.seg_type    = emit_seg ? flg_d[5:0] : '0;
    rec_o.ref_count   = emit_seg ? refc_d : '0;
    rec_o.page_assoc  = emit_seg ? pa_d : '0;
    rec_o.data_length = emit_seg ? emit_dlen : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID; cnt_q <= '0; fs_q <= '0; segn_q <= '0; flg_q <= '0;
      refc_q <= '0; pa_q <= '0; seq_q <= 1'b0; pages_q <= '0;
    end else if (beat_i) begin
      phase_q <= phase_d; cnt_q <= cnt_d; fs_q <= fs_d; segn_q <= segn_d; flg_q <= flg_d;
      refc_q <= refc_d; pa_q <= pa_d; seq_q <= seq_d; pages_q <= pages_d;
    end
  end

endmodule

/* rtl/jsh_queue.sv */
// short record queue between parser and output stage
module jsh_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsh_pkg::rec_t rec_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output jsh_pkg::rec_t rec_o
);
  import jsh_pkg::*;

  rec_t              mem_q [QUEUE_DEPTH];
  rec_t              head_q;
  logic [QUEUE_AW-1:0] wr_q, rd_q, rd_nxt;
  logic [QUEUE_AW:0]   cnt_q;

  assign full_o  = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rd_nxt  = pop_i ? rd_q + 1'b1 : rd_q;
  assign rec_o   = head_q;

  // head register tracks the entry at the read pointer, a write to it passes straight in
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
    if (push_i && wr_q == rd_nxt) head_q <= rec_i;
    else head_q <= mem_q[rd_nxt];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/jsh_back.sv */
// output stage: takes records from the queue, decodes type flags, holds the output beat
module jsh_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  jsh_pkg::rec_t rec_i,
  output logic          pop_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [167:0]  m_axis_tdata,
  output logic [1:0]    m_axis_tuser
);
  import jsh_pkg::*;

  rec_t       out_q;
  logic [3:0] flags_q, flags_d;
  logic       valid_q;
  logic       is_seg;

  assign pop_o  = !empty_i && (!valid_q || m_axis_tready);
  assign is_seg = (rec_i.kind == KIND_SEG_HDR);

  always_comb begin
    flags_d[0] = is_seg && rec_i.seg_type == TYPE_PAGE_INFO;
    flags_d[1] = is_seg && rec_i.seg_type == TYPE_END_OF_PAGE;
    flags_d[2] = is_seg && rec_i.seg_type == TYPE_END_OF_STRIPE;
    flags_d[3] = is_seg && rec_i.seg_type == TYPE_END_OF_FILE;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q   <= rec_i;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (pop_o) valid_q <= 1'b1;
    else if (m_axis_tready) valid_q <= 1'b0;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {flags_q, out_q.data_length, out_q.page_assoc, out_q.ref_count,
                          out_q.seg_type, out_q.seg_number, out_q.page_count, out_q.seq_org};

endmodule

/* rtl/jbig2_segment_header_parser_top.sv */
// JBIG2 file and segment header parser: one byte per cycle unless the queue is full;
// records come out in order, each through the queue head and output registers
// throughput: 1 byte per cycle while the queue has room, set by the single-byte parser step;
// a 4-entry record queue and an output register let input keep flowing while a record waits
// reset (rst_ni low, asynchronous) returns the parser to the ID string and empties the queue
module jbig2_segment_header_parser_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tuser,   // restart
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // sequential_org, page_count, segment_number, segment_type, referred_count,
  // page_association, data_length, is_page_info, is_end_of_page, is_end_of_stripe,
  // is_end_of_file
  output logic [167:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // record_kind
);
  import jsh_pkg::*;

  rec_t front_rec, head_rec;
  logic push, pop, full, empty, beat;

  assign s_axis_tready = !full;
  assign beat          = s_axis_tvalid && s_axis_tready;

  jsh_front u_front (
    .clk_i, .rst_ni, .beat_i(beat), .data_byte_i(s_axis_tdata),
    .restart_i(s_axis_tuser), .push_o(push), .rec_o(front_rec)
  );

  jsh_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .rec_i(front_rec), .full_o(full),
    .empty_o(empty), .pop_i(pop), .rec_o(head_rec)
  );

  jsh_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .rec_i(head_rec), .pop_o(pop),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

endmodule

/* tb/testbench.sv */
// self-checking testbench for the jbig2 file and segment header parser
`timescale 1ns / 100ps

module testbench;
  import jsh_pkg::*;

  typedef enum logic [3:0] {
    P_ID, P_FHFLAGS, P_PAGES, P_SEGNUM, P_SEGFLAGS, P_REFBYTE, P_REFLONG,
    P_RETAIN, P_REFNUMS, P_PAGEASSOC, P_DATALEN, P_SKIPDATA, P_DONE, P_HALT
  } phase_e;

  typedef struct {
    logic [1:0]  kind;
    logic        seq;
    logic [31:0] pages;
    logic [31:0] num;
    logic [5:0]  typ;
    logic [28:0] refc;
    logic [31:0] pa;
    logic [31:0] dlen;
    logic        pinfo, eop, eos, eof;
  } hdr_rec_t;

  localparam int unsigned NUM_ITEMS = 1050;
  localparam int unsigned IDLE_LIMIT = 4000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  jbig2_segment_header_parser_top u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // parser mirror state
  phase_e      ph;
  logic [31:0] cnt, shft, seg_num, ref_cnt, pa_reg, pages_reg;
  logic [7:0]  seg_flags;
  logic        seq_reg;

  hdr_rec_t    rec_q[$];
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  bit          no_idle = 0;
  int unsigned idle_cycles = 0;

  function automatic logic known_type(input logic [5:0] t);
    case (t)
      0, 4, 6, 7, 16, 20, 22, 23, 36, 38, 39, 40, 42, 43,
      48, 49, 50, 51, 52, 53, 62: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic hdr_rec_t make_rec(input logic [1:0] kind, input bit seg,
                                        input logic [31:0] dlen);
    hdr_rec_t r;
    logic [5:0] t;
    t = seg_flags[5:0];
    r.kind  = kind;
    r.seq   = seq_reg;
    r.pages = pages_reg;
    r.num   = seg ? seg_num : '0;
    r.typ   = seg ? t : '0;
    r.refc  = seg ? ref_cnt[28:0] : '0;
    r.pa    = seg ? pa_reg : '0;
    r.dlen  = seg ? dlen : '0;
    r.pinfo = seg && t == TYPE_PAGE_INFO;
    r.eop   = seg && t == TYPE_END_OF_PAGE;
    r.eos   = seg && t == TYPE_END_OF_STRIPE;
    r.eof   = seg && t == TYPE_END_OF_FILE;
    return r;
  endfunction

  function automatic void clear_parser();
    ph = P_ID;
    cnt = 0; shft = 0; seg_num = 0; seg_flags = 0; ref_cnt = 0;
    pa_reg = 0; seq_reg = 0; pages_reg = 0;
  endfunction

  function automatic void go_segnum();
    ph = P_SEGNUM; cnt = 4; shft = 0;
  endfunction

  function automatic void go_pageassoc();
    ph = P_PAGEASSOC; cnt = seg_flags[6] ? 4 : 1; shft = 0;
  endfunction

  function automatic void go_refnums();
    logic [31:0] w;
    if (seg_num <= REF_NARROW_MAX) w = 1;
    else if (seg_num <= REF_MID_MAX) w = 2;
    else w = 4;
    cnt = {3'b0, ref_cnt[28:0]} * w;
    if (cnt == 0) go_pageassoc();
    else ph = P_REFNUMS;
  endfunction

  // advance the mirror by one byte, queue the record it completes
  function automatic void parse_byte(input logic [7:0] b, input logic rs);
    hdr_rec_t r;
    if (rs) clear_parser();
    case (ph)
      P_ID: begin
        if (b != id_byte(cnt[2:0])) begin
          rec_q.push_back(make_rec(KIND_BAD_ID, 0, 0));
          ph = P_HALT;
        end else begin
          cnt++;
          if (cnt >= 8) begin cnt = 0; ph = P_FHFLAGS; end
        end
      end
      P_FHFLAGS: begin
        seq_reg = b[0];
        if (b[1]) begin
          pages_reg = 0;
          rec_q.push_back(make_rec(KIND_FILE_HDR, 0, 0));
          go_segnum();
        end else begin
          ph = P_PAGES; cnt = 4; shft = 0;
        end
      end
      P_PAGES: begin
        shft = {shft[23:0], b}; cnt--;
        if (cnt == 0) begin
          pages_reg = shft;
          rec_q.push_back(make_rec(KIND_FILE_HDR, 0, 0));
          go_segnum();
        end
      end
      P_SEGNUM: begin
        shft = {shft[23:0], b}; cnt--;
        if (cnt == 0) begin seg_num = shft; ph = P_SEGFLAGS; end
      end
      P_SEGFLAGS: begin
        seg_flags = b; ref_cnt = 0; pa_reg = 0;
        if (!known_type(b[5:0])) begin
          r = make_rec(KIND_BAD_TYPE, 1, 0);
          r.pinfo = 0; r.eop = 0; r.eos = 0; r.eof = 0;
          rec_q.push_back(r);
          ph = P_HALT;
        end else if (seq_reg && b[5:0] == TYPE_END_OF_FILE) begin
          rec_q.push_back(make_rec(KIND_SEG_HDR, 1, 0));
          ph = P_DONE;
        end else begin
          ph = P_REFBYTE;
        end
      end
      P_REFBYTE: begin
        if (b[7:5] == REF_LONG_FORM) begin
          shft = {27'b0, b[4:0]}; cnt = 3; ph = P_REFLONG;
        end else begin
          ref_cnt = {29'b0, b[7:5]};
          go_refnums();
        end
      end
      P_REFLONG: begin
        shft = {shft[23:0], b}; cnt--;
        if (cnt == 0) begin
          ref_cnt = {3'b0, shft[28:0]};
          cnt = (ref_cnt + 8) >> 3;
          ph = P_RETAIN;
        end
      end
      P_RETAIN: begin
        cnt--;
        if (cnt == 0) go_refnums();
      end
      P_REFNUMS: begin
        cnt--;
        if (cnt == 0) go_pageassoc();
      end
      P_PAGEASSOC: begin
        shft = {shft[23:0], b}; cnt--;
        if (cnt == 0) begin
          pa_reg = shft; ph = P_DATALEN; cnt = 4; shft = 0;
        end
      end
      P_DATALEN: begin
        shft = {shft[23:0], b}; cnt--;
        if (cnt == 0) begin
          rec_q.push_back(make_rec(KIND_SEG_HDR, 1, shft));
          if (seg_flags[5:0] == TYPE_END_OF_FILE) ph = P_DONE;
          else if (seq_reg && shft != 0) begin cnt = shft; ph = P_SKIPDATA; end
          else go_segnum();
        end
      end
      P_SKIPDATA: begin
        cnt--;
        if (cnt == 0) go_segnum();
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic rs = 1'b0);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= rs;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_byte(b, rs);
    bytes_sent++;
  endtask

  task automatic send_u32(input logic [31:0] v);
    for (int i = 3; i >= 0; i--) send_byte(v[8*i +: 8]);
  endtask

  // bad_pos 8 gives a clean id string
  task automatic send_id(input int bad_pos = 8);
    logic [7:0] b;
    for (int i = 0; i < 8; i++) begin
      b = id_byte(i[2:0]);
      if (i == bad_pos) b = b ^ 8'($urandom_range(255, 1));
      send_byte(b, i == 0);
      if (i == bad_pos) return;
    end
  endtask

  task automatic send_file_hdr(input logic seq, input logic no_pages,
                               input logic [31:0] pages);
    logic [7:0] f;
    f = {6'($urandom), no_pages, seq};
    send_byte(f);
    if (!no_pages) send_u32(pages);
  endtask

  task automatic send_segment(input logic seq, input logic [31:0] num,
                              input logic [7:0] flags, input logic long_form,
                              input logic [28:0] rcount, input logic [31:0] pa,
                              input logic [31:0] dlen, input int max_skip = -1);
    int unsigned w, nret;
    send_u32(num);
    send_byte(flags);
    if (!known_type(flags[5:0])) return;
    if (seq && flags[5:0] == TYPE_END_OF_FILE) return;
    if (long_form) begin
      send_byte({REF_LONG_FORM, rcount[28:24]});
      send_byte(rcount[23:16]);
      send_byte(rcount[15:8]);
      send_byte(rcount[7:0]);
      nret = (rcount + 8) >> 3;
      repeat (nret) send_byte(8'($urandom));
    end else begin
      send_byte({rcount[2:0], 5'($urandom)});
    end
    w = num <= 256 ? 1 : (num <= 65536 ? 2 : 4);
    repeat (rcount * w) send_byte(8'($urandom));
    if (flags[6]) send_u32(pa);
    else send_byte(pa[7:0]);
    send_u32(dlen);
    if (seq && flags[5:0] != TYPE_END_OF_FILE) begin
      for (longint i = 0; i < dlen; i++) begin
        if (max_skip >= 0 && i >= max_skip) break;
        send_byte(8'($urandom));
      end
    end
  endtask

  function automatic logic [5:0] rand_known_type();
    logic [5:0] t;
    do t = 6'($urandom); while (!known_type(t));
    return t;
  endfunction

  function automatic logic [31:0] rand_segnum();
    case ($urandom_range(3))
      0: return $urandom_range(256);
      1: return $urandom_range(65536, 257);
      2: return $urandom_range(300000, 65537);
      default: return $urandom;
    endcase
  endfunction

  // ---------------- directed tests

  task automatic test_file_headers();
    send_id(); send_file_hdr(0, 0, 32'hFFFF_FFFF);
    send_id(); send_file_hdr(1, 1, 0);
    send_id(); send_file_hdr(1, 0, 32'h0000_0000);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_bad_id();
    send_id(0);
    send_byte(8'h00);
    send_id(7);
  endtask

  task automatic test_unknown_type();
    send_id(); send_file_hdr(0, 1, 0);
    send_segment(0, 32'd5, 8'hC1, 0, 0, 0, 0);
    send_byte(8'hAA);
  endtask

  task automatic test_ref_widths();
    send_id(); send_file_hdr(0, 1, 0);
    send_segment(0, 32'd256, {2'b01, TYPE_PAGE_INFO}, 0, 3, 32'h0102_0304, 32'd19);
    send_segment(0, 32'd257, {2'b00, TYPE_END_OF_PAGE}, 0, 2, 32'h7F, 0);
    send_segment(0, 32'd65536, {2'b10, TYPE_END_OF_STRIPE}, 0, 5, 32'h1, 32'hFFFF_FFFF);
    send_segment(0, 32'd65537, 8'd0, 0, 6, 32'h0, 32'd1);
    send_segment(0, 32'hFFFF_FFFF, 8'd62, 1, 29'd9, 32'h0, 32'd2);
    send_segment(0, 32'd3, {2'b00, TYPE_END_OF_FILE}, 0, 0, 0, 0);
    repeat (3) send_byte(8'($urandom));
  endtask

  task automatic test_sequential();
    send_id(); send_file_hdr(1, 0, 32'd1);
    send_segment(1, 32'd0, 8'd48, 0, 0, 32'd1, 32'd3);
    send_segment(1, 32'd1, 8'd36, 1, 29'd0, 32'd1, 32'd0);
    send_segment(1, 32'd2, 8'd53, 0, 1, 32'd1, 32'hFFFF_FFFF, 5);
    send_id(); send_file_hdr(1, 1, 0);
    send_segment(1, 32'd9, {2'b11, TYPE_END_OF_FILE}, 0, 0, 0, 0);
    send_byte(8'h55);
  endtask

  // ---------------- random traffic

  task automatic test_random_files();
    logic seq;
    logic [5:0] t;
    logic [31:0] dlen;
    int nseg;
    while (bytes_sent < NUM_ITEMS) begin
      no_idle = $urandom_range(9) == 0;
      if ($urandom_range(99) < 12) begin
        repeat ($urandom_range(12, 1))
          send_byte(8'($urandom), $urandom_range(9) == 0);
        continue;
      end
      send_id($urandom_range(19) == 0 ? $urandom_range(7) : 8);
      seq = 1'($urandom_range(1));
      send_file_hdr(seq, 1'($urandom_range(1)), $urandom);
      nseg = $urandom_range(5, 1);
      for (int s = 0; s < nseg; s++) begin
        t = $urandom_range(19) == 0 ? 6'($urandom) : rand_known_type();
        if (s == nseg - 1 && $urandom_range(2) == 0) t = TYPE_END_OF_FILE;
        dlen = seq ? $urandom_range(12) : $urandom;
        if ($urandom_range(9) == 0)
          send_segment(seq, rand_segnum(), {2'($urandom), t}, 1,
                       29'($urandom_range(40)), $urandom, dlen);
        else
          send_segment(seq, rand_segnum(), {2'($urandom), t}, 0,
                       29'($urandom_range(6)), $urandom, dlen);
        if (!known_type(t)) break;
      end
      repeat ($urandom_range(3)) send_byte(8'($urandom));
    end
    no_idle = 0;
  endtask

  // ---------------- result checking

  task automatic cmp_field(input string nm, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, nm, e, a);
      errors++;
    end
  endtask

  int unsigned stall = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    hdr_rec_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (rec_q.size() == 0) begin
          $display("%0t unexpected record: expected none actual kind %0d tdata %h",
                   $time, m_axis_tuser, m_axis_tdata);
          errors++;
        end else begin
          e = rec_q.pop_front();
          cmp_field("record_kind", 32'(e.kind), 32'(m_axis_tuser));
          cmp_field("sequential_org", 32'(e.seq), 32'(m_axis_tdata[0]));
          cmp_field("page_count", e.pages, m_axis_tdata[32:1]);
          cmp_field("segment_number", e.num, m_axis_tdata[64:33]);
          cmp_field("segment_type", 32'(e.typ), 32'(m_axis_tdata[70:65]));
          cmp_field("referred_count", 32'(e.refc), 32'(m_axis_tdata[99:71]));
          cmp_field("page_association", e.pa, m_axis_tdata[131:100]);
          cmp_field("data_length", e.dlen, m_axis_tdata[163:132]);
          cmp_field("is_page_info", 32'(e.pinfo), 32'(m_axis_tdata[164]));
          cmp_field("is_end_of_page", 32'(e.eop), 32'(m_axis_tdata[165]));
          cmp_field("is_end_of_stripe", 32'(e.eos), 32'(m_axis_tdata[166]));
          cmp_field("is_end_of_file", 32'(e.eof), 32'(m_axis_tdata[167]));
        end
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        stall = no_idle ? 0 : pick_gap();
        m_axis_tready <= stall == 0;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    clear_parser();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_file_headers();
    test_bad_id();
    test_unknown_type();
    test_ref_widths();
    test_sequential();
    test_random_files();
    s_axis_tvalid <= 1'b0;
    while (rec_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* jbig2_segment_header_parser_top.f */
rtl/jsh_pkg.sv
rtl/jsh_front.sv
rtl/jsh_queue.sv
rtl/jsh_back.sv
rtl/jbig2_segment_header_parser_top.sv
tb/testbench.sv
